/* sv/filtered_k_way_merge_assert.svh */
// Assertion macros used by the filtered k-way merge top level.
`ifndef FILTERED_K_WAY_MERGE_ASSERT_SVH
`define FILTERED_K_WAY_MERGE_ASSERT_SVH

`ifndef SYNTHESIS

// Checks that a property holds at every clock edge outside of reset.
`define FKM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a condition never holds outside of reset.
`define FKM_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`else

`define FKM_ASSERT(lbl, prop, msg)
`define FKM_ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

/* sv/fkm_pkg.sv */
// Shared types and constants of the filtered k-way merge.
package fkm_pkg;

  // Field widths of the input and result items.
  localparam int unsigned POS_W     = 32;
  localparam int unsigned SRC_W     = 4;
  localparam int unsigned CHROM_W   = 5;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_SOURCES    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_CHROMOSOME = 2'd1;

  localparam logic [CFG_DATA_W-1:0] ACTIVE_SOURCES_RST    = 5'd16;
  localparam logic [CFG_DATA_W-1:0] TARGET_CHROMOSOME_RST = 5'd0;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take_item;
    logic scan_init;
    logic scan_run;
    logic emit;
  } fkm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic any_waiting;
    logic scan_done;
    logic out_free;
  } fkm_sts_t;

endpackage

/* sv/fkm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module fkm_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/fkm_ctrl.sv */
// Controller state machine of the filtered k-way merge.
module fkm_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  fkm_pkg::fkm_sts_t sts_i,
  output fkm_pkg::fkm_cmd_t cmd_o
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CHECK = 2'd1;
  localparam logic [1:0] S_SCAN  = 2'd2;
  localparam logic [1:0] S_EMIT  = 2'd3;

  logic [1:0] state_q;
  logic [1:0] state_d;

  // Next state and command decode.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.take_item = 1'b1;
          state_d         = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts_i.any_waiting) begin
          state_d = S_IDLE;
        end else begin
          cmd_o.scan_init = 1'b1;
          state_d         = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan_run = 1'b1;
        if (sts_i.scan_done) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Items are taken only while the controller is idle.
  assign in_stall_o = (state_q != S_IDLE);

endmodule

/* sv/fkm_dpath.sv */
// Datapath of the filtered k-way merge: head store, flags, minimum scan, result register.
module fkm_dpath #(
  parameter int unsigned SOURCES = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Configuration writes.
  input  logic                             cfg_valid_i,
  input  logic [fkm_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [fkm_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  // Input item fields.
  input  logic [fkm_pkg::SRC_W-1:0]        in_source_index_i,
  input  logic                             in_source_ended_i,
  input  logic [fkm_pkg::CHROM_W-1:0]      in_chromosome_code_i,
  input  logic [fkm_pkg::POS_W-1:0]        in_interval_start_i,
  input  logic [fkm_pkg::POS_W-1:0]        in_interval_stop_i,
  // Controller interface.
  input  fkm_pkg::fkm_cmd_t                cmd_i,
  output fkm_pkg::fkm_sts_t                sts_o,
  // Result channel.
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [fkm_pkg::POS_W-1:0]        out_merged_start_o,
  output logic [fkm_pkg::POS_W-1:0]        out_merged_stop_o,
  output logic [fkm_pkg::SRC_W-1:0]        out_winner_source_o,
  output logic                             out_pass_done_o
);

  localparam int unsigned IDX_W = $clog2(SOURCES);
  localparam int unsigned CNT_W = $clog2(SOURCES + 1);
  localparam int unsigned HEAD_W = 2 * fkm_pkg::POS_W;

  // Configuration registers.
  logic [fkm_pkg::CFG_DATA_W-1:0] active_q;
  logic [fkm_pkg::CFG_DATA_W-1:0] target_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= fkm_pkg::ACTIVE_SOURCES_RST;
      target_q <= fkm_pkg::TARGET_CHROMOSOME_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        fkm_pkg::CFG_ACTIVE_SOURCES:    active_q <= cfg_data_i;
        fkm_pkg::CFG_TARGET_CHROMOSOME: target_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Active source count, clamped to the range one to SOURCES.
  logic [CNT_W-1:0]   n_act;
  logic [SOURCES-1:0] act_mask;

  always_comb begin
    if (active_q == '0) begin
      n_act = CNT_W'(1);
    end else if (32'(active_q) > 32'(SOURCES)) begin
      n_act = CNT_W'(SOURCES);
    end else begin
      n_act = CNT_W'(active_q);
    end
  end

  always_comb begin
    for (int i = 0; i < SOURCES; i++) begin
      act_mask[i] = (32'(i) < 32'(n_act));
    end
  end

  // Per-source flags.
  logic [SOURCES-1:0] present_q;
  logic [SOURCES-1:0] present_d;
  logic [SOURCES-1:0] waiting_q;
  logic [SOURCES-1:0] waiting_d;

  // Input item decode.
  logic [31:0]      item_src_ext;
  logic [IDX_W-1:0] item_idx;
  logic             item_hit;
  logic             chrom_match;
  logic             head_we;

  assign item_src_ext = 32'(in_source_index_i);
  assign item_idx     = item_src_ext[IDX_W-1:0];
  assign item_hit     = (item_src_ext < 32'(n_act)) && waiting_q[item_idx];
  assign chrom_match  = (in_chromosome_code_i == target_q);
  assign head_we      = cmd_i.take_item && item_hit && !in_source_ended_i && chrom_match;

  // Scan state.
  logic [CNT_W-1:0]         scan_q;
  logic                     cmp_vld_q;
  logic [IDX_W-1:0]         cmp_idx_q;
  logic                     found_q;
  logic [IDX_W-1:0]         best_idx_q;
  logic [fkm_pkg::POS_W-1:0] best_start_q;
  logic [fkm_pkg::POS_W-1:0] best_stop_q;
  logic [HEAD_W-1:0]        rd_head;
  logic [fkm_pkg::POS_W-1:0] rd_start;
  logic [fkm_pkg::POS_W-1:0] rd_stop;
  logic                     scan_issue;
  logic                     cmp_take;

  // Head record store, one entry per source holding stop and start.
  fkm_ram #(
    .WIDTH (HEAD_W),
    .DEPTH (SOURCES)
  ) u_head_ram (
    .clk_i   (clk_i),
    .we_i    (head_we),
    .waddr_i (item_idx),
    .wdata_i ({in_interval_stop_i, in_interval_start_i}),
    .raddr_i (scan_q[IDX_W-1:0]),
    .rdata_o (rd_head)
  );

  assign rd_start = rd_head[fkm_pkg::POS_W-1:0];
  assign rd_stop  = rd_head[HEAD_W-1:fkm_pkg::POS_W];

  // One address is issued per cycle; its data is compared in the next cycle.
  assign scan_issue = cmd_i.scan_run && (scan_q != n_act);
  assign cmp_take   = cmd_i.scan_run && cmp_vld_q && present_q[cmp_idx_q] &&
                      (!found_q || (rd_start < best_start_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q    <= '0;
      cmp_vld_q <= 1'b0;
      cmp_idx_q <= '0;
      found_q   <= 1'b0;
    end else if (cmd_i.scan_init) begin
      scan_q    <= '0;
      cmp_vld_q <= 1'b0;
      found_q   <= 1'b0;
    end else if (cmd_i.scan_run) begin
      cmp_vld_q <= scan_issue;
      if (scan_issue) begin
        scan_q    <= scan_q + CNT_W'(1);
        cmp_idx_q <= scan_q[IDX_W-1:0];
      end
      if (cmp_take) begin
        found_q <= 1'b1;
      end
    end
  end

  // Running minimum; the strict compare keeps the lowest index on a tie.
  always_ff @(posedge clk_i) begin
    if (cmp_take) begin
      best_idx_q   <= cmp_idx_q;
      best_start_q <= rd_start;
      best_stop_q  <= rd_stop;
    end
  end

  // Flag updates for an item and for an emitted result.
  always_comb begin
    present_d = present_q;
    waiting_d = waiting_q;
    if (cmd_i.take_item && item_hit) begin
      if (in_source_ended_i) begin
        present_d[item_idx] = 1'b0;
        waiting_d[item_idx] = 1'b0;
      end else if (chrom_match) begin
        present_d[item_idx] = 1'b1;
        waiting_d[item_idx] = 1'b0;
      end
    end
    if (cmd_i.emit) begin
      if (found_q) begin
        present_d[best_idx_q] = 1'b0;
        waiting_d[best_idx_q] = 1'b1;
      end else begin
        present_d = '0;
        waiting_d = '1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q <= '0;
      waiting_q <= '1;
    end else begin
      present_q <= present_d;
      waiting_q <= waiting_d;
    end
  end

  // Result register.
  logic                      out_valid_q;
  logic [fkm_pkg::POS_W-1:0] out_start_q;
  logic [fkm_pkg::POS_W-1:0] out_stop_q;
  logic [fkm_pkg::SRC_W-1:0] out_winner_q;
  logic                      out_done_q;
  logic [31:0]               best_idx_ext;

  assign best_idx_ext = 32'(best_idx_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      if (found_q) begin
        out_start_q  <= best_start_q;
        out_stop_q   <= best_stop_q;
        out_winner_q <= best_idx_ext[fkm_pkg::SRC_W-1:0];
        out_done_q   <= 1'b0;
      end else begin
        out_start_q  <= '0;
        out_stop_q   <= '0;
        out_winner_q <= '0;
        out_done_q   <= 1'b1;
      end
    end
  end

  // Status to the controller.
  assign sts_o.any_waiting = |(waiting_q & act_mask);
  assign sts_o.scan_done   = (scan_q == n_act) && !cmp_vld_q;
  assign sts_o.out_free    = !out_valid_q || !out_stall_i;

  assign out_valid_o         = out_valid_q;
  assign out_merged_start_o  = out_start_q;
  assign out_merged_stop_o   = out_stop_q;
  assign out_winner_source_o = out_winner_q;
  assign out_pass_done_o     = out_done_q;

endmodule

/* sv/filtered_k_way_merge.sv */
// Top level of the filtered k-way merge of interval records.
//
// Input channel: an item for an active, waiting source loads its head record or
// marks it exhausted; other items are ignored. Records whose chromosome code
// differs from the target register are dropped and the source keeps waiting.
// Output channel: once no active source waits, the head with the smallest start
// (lowest source on a tie) leaves as a result; when all sources are exhausted a
// pass_done result leaves instead and every source is rearmed.
// Configuration: a valid/ready write port, always ready, index 0 sets the active
// source count and index 1 the target chromosome.
// Handling: an item that leaves a source still waiting passes the check state
// and the controller returns to idle. An item that completes the set starts the
// minimum search, which reads the head of each active source, one per cycle,
// through the one read port of the head store, and the result is then loaded;
// the next item can be taken in the cycle after. Items are taken one at a time.
// The result register keeps a finished result while the receiver stalls, and the
// next item is taken meanwhile; a new result waits until the register is free.
// Reset clears all flags to waiting with no record, active count 16, target 0.
// The head store itself is not cleared.
`include "filtered_k_way_merge_assert.svh"

module filtered_k_way_merge #(
  parameter int unsigned SOURCES = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration write channel.
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [fkm_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [fkm_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // Input channel.
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [fkm_pkg::SRC_W-1:0]      in_source_index_i,
  input  logic                           in_source_ended_i,
  input  logic [fkm_pkg::CHROM_W-1:0]    in_chromosome_code_i,
  input  logic [fkm_pkg::POS_W-1:0]      in_interval_start_i,
  input  logic [fkm_pkg::POS_W-1:0]      in_interval_stop_i,
  // Output channel.
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [fkm_pkg::POS_W-1:0]      out_merged_start_o,
  output logic [fkm_pkg::POS_W-1:0]      out_merged_stop_o,
  output logic [fkm_pkg::SRC_W-1:0]      out_winner_source_o,
  output logic                           out_pass_done_o
);

  fkm_pkg::fkm_cmd_t cmd;
  fkm_pkg::fkm_sts_t sts;

  // Configuration writes are taken in any cycle.
  assign cfg_ready_o = 1'b1;

  fkm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  fkm_dpath #(
    .SOURCES (SOURCES)
  ) u_dpath (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_valid_i          (cfg_valid_i),
    .cfg_index_i          (cfg_index_i),
    .cfg_data_i           (cfg_data_i),
    .in_source_index_i    (in_source_index_i),
    .in_source_ended_i    (in_source_ended_i),
    .in_chromosome_code_i (in_chromosome_code_i),
    .in_interval_start_i  (in_interval_start_i),
    .in_interval_stop_i   (in_interval_stop_i),
    .cmd_i                (cmd),
    .sts_o                (sts),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .out_merged_start_o   (out_merged_start_o),
    .out_merged_stop_o    (out_merged_stop_o),
    .out_winner_source_o  (out_winner_source_o),
    .out_pass_done_o      (out_pass_done_o)
  );

  // A result is never loaded over one that the receiver has not yet taken.
  `FKM_ASSERT(a_emit_into_free,
              cmd.emit |-> (!out_valid_o || !out_stall_i),
              "emit over held result")

  // A transfer on the input channel closes the input until the item is handled.
  `FKM_ASSERT(a_stall_after_take, cmd.take_item |=> in_stall_o, "input open after transfer")

  // A pass_done result carries no record.
  `FKM_ASSERT(a_done_is_empty,
              (out_valid_o && out_pass_done_o) |-> (out_merged_start_o == '0 &&
              out_merged_stop_o == '0 && out_winner_source_o == '0),
              "done result carries data")

  // At most one controller command is active in a cycle.
  `FKM_ASSERT_NEVER(a_cmd_onehot, !$onehot0(cmd), "overlapping commands")

endmodule

/* test/tb.sv */
// Testbench of the filtered k-way merge: directed and random streams against a predictor.
module tb;

  localparam int SOURCES       = 16;
  localparam int SETTLE_CYCLES = 2 * (SOURCES + 4);
  localparam int QUIET_LIMIT   = 2000;

  // One input transfer and one merged result.
  typedef struct packed {
    logic [fkm_pkg::SRC_W-1:0]   src;
    logic                        ended;
    logic [fkm_pkg::CHROM_W-1:0] chrom;
    logic [fkm_pkg::POS_W-1:0]   begin_pos;
    logic [fkm_pkg::POS_W-1:0]   end_pos;
  } record_t;

  typedef struct packed {
    logic [fkm_pkg::POS_W-1:0] begin_pos;
    logic [fkm_pkg::POS_W-1:0] end_pos;
    logic [fkm_pkg::SRC_W-1:0] winner;
    logic                      done;
  } merged_t;

  logic                           clk_i                = 1'b0;
  logic                           rst_ni               = 1'b0;
  logic                           cfg_valid_i          = 1'b0;
  logic                           cfg_ready_o;
  logic [fkm_pkg::CFG_IDX_W-1:0]  cfg_index_i          = '0;
  logic [fkm_pkg::CFG_DATA_W-1:0] cfg_data_i           = '0;
  logic                           in_valid_i           = 1'b0;
  logic                           in_stall_o;
  logic [fkm_pkg::SRC_W-1:0]      in_source_index_i    = '0;
  logic                           in_source_ended_i    = 1'b0;
  logic [fkm_pkg::CHROM_W-1:0]    in_chromosome_code_i = '0;
  logic [fkm_pkg::POS_W-1:0]      in_interval_start_i  = '0;
  logic [fkm_pkg::POS_W-1:0]      in_interval_stop_i   = '0;
  logic                           out_valid_o;
  logic                           out_stall_i          = 1'b0;
  logic [fkm_pkg::POS_W-1:0]      out_merged_start_o;
  logic [fkm_pkg::POS_W-1:0]      out_merged_stop_o;
  logic [fkm_pkg::SRC_W-1:0]      out_winner_source_o;
  logic                           out_pass_done_o;

  // Shadow copy of the head store, the flags and the registers.
  logic [fkm_pkg::POS_W-1:0]      shadow_begin [SOURCES];
  logic [fkm_pkg::POS_W-1:0]      shadow_end [SOURCES];
  logic                           shadow_full [SOURCES];
  logic                           shadow_hungry [SOURCES];
  logic [fkm_pkg::CFG_DATA_W-1:0] shadow_active;
  logic [fkm_pkg::CFG_DATA_W-1:0] shadow_target;

  merged_t pending_merges [$];
  merged_t next_merge;
  int      errors       = 0;
  int      taken_items  = 0;
  int      quiet_cycles = 0;
  int      rx_hold      = 0;
  bit      result_taken = 1'b0;
  bit      src_idle     = 1'b1;
  bit      sink_idle    = 1'b1;

  always #5 clk_i = ~clk_i;

  filtered_k_way_merge #(
    .SOURCES(SOURCES)
  ) dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .in_source_index_i   (in_source_index_i),
    .in_source_ended_i   (in_source_ended_i),
    .in_chromosome_code_i(in_chromosome_code_i),
    .in_interval_start_i (in_interval_start_i),
    .in_interval_stop_i  (in_interval_stop_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .out_merged_start_o  (out_merged_start_o),
    .out_merged_stop_o   (out_merged_stop_o),
    .out_winner_source_o (out_winner_source_o),
    .out_pass_done_o     (out_pass_done_o)
  );

  // Number of sources in the merge, with zero and oversize values clamped.
  function automatic int live_sources();
    if (shadow_active == '0) return 1;
    if (int'(shadow_active) > SOURCES) return SOURCES;
    return int'(shadow_active);
  endfunction

  // Applies one record to the shadow state and works out the merged result, if any.
  function automatic bit merge_predict(input record_t rec, output bit used, output merged_t res);
    int  n;
    int  best;
    bit  found;
    n     = live_sources();
    best  = 0;
    found = 1'b0;
    used  = 1'b0;
    res   = '0;
    if (int'(rec.src) < n && shadow_hungry[rec.src]) begin
      used = 1'b1;
      if (rec.ended) begin
        shadow_hungry[rec.src] = 1'b0;
        shadow_full[rec.src]   = 1'b0;
      end else if (rec.chrom == shadow_target) begin
        shadow_begin[rec.src]  = rec.begin_pos;
        shadow_end[rec.src]    = rec.end_pos;
        shadow_full[rec.src]   = 1'b1;
        shadow_hungry[rec.src] = 1'b0;
      end
    end
    for (int i = 0; i < n; i++) begin
      if (shadow_hungry[i]) return 1'b0;
    end
    for (int i = 0; i < n; i++) begin
      if (shadow_full[i] && (!found || shadow_begin[i] < shadow_begin[best])) begin
        best  = i;
        found = 1'b1;
      end
    end
    if (found) begin
      res.begin_pos       = shadow_begin[best];
      res.end_pos         = shadow_end[best];
      res.winner          = best[fkm_pkg::SRC_W-1:0];
      shadow_full[best]   = 1'b0;
      shadow_hungry[best] = 1'b1;
    end else begin
      res.done = 1'b1;
      for (int i = 0; i < SOURCES; i++) begin
        shadow_full[i]   = 1'b0;
        shadow_hungry[i] = 1'b1;
      end
    end
    return 1'b1;
  endfunction

  // Start positions biased toward ties and the ends of the range.
  function automatic logic [fkm_pkg::POS_W-1:0] rand_pos();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(0, 15);
      2: return $urandom_range(0, 1) ? '1 : '0;
      default: return 32'hFFFF_FFF0 + $urandom_range(0, 15);
    endcase
  endfunction

  // Random values of exactly the field widths.
  function automatic logic [fkm_pkg::SRC_W-1:0] rand_src();
    logic [31:0] r;
    r = $urandom;
    return r[fkm_pkg::SRC_W-1:0];
  endfunction

  function automatic logic [fkm_pkg::CHROM_W-1:0] rand_chrom();
    logic [31:0] r;
    r = $urandom;
    return r[fkm_pkg::CHROM_W-1:0];
  endfunction

  function automatic logic rand_bit();
    logic [31:0] r;
    r = $urandom;
    return r[0];
  endfunction

  // Writes one configuration register and mirrors it.
  task automatic cfg_write(input logic [fkm_pkg::CFG_IDX_W-1:0] idx,
                           input logic [fkm_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == fkm_pkg::CFG_ACTIVE_SOURCES) shadow_active = val;
    else if (idx == fkm_pkg::CFG_TARGET_CHROMOSOME) shadow_target = val;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Sends one record, after a random gap while the source may idle, and queues its expected result, if any.
  task automatic send_rec(input logic [fkm_pkg::SRC_W-1:0] src, input logic ended,
                          input logic [fkm_pkg::CHROM_W-1:0] chrom,
                          input logic [fkm_pkg::POS_W-1:0] begin_pos,
                          input logic [fkm_pkg::POS_W-1:0] end_pos);
    record_t rec;
    merged_t res;
    bit      used;
    int      gap;
    rec = '{src: src, ended: ended, chrom: chrom, begin_pos: begin_pos, end_pos: end_pos};
    gap = src_idle ? $urandom_range(0, 3) : 0;
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i           <= 1'b1;
    in_source_index_i    <= rec.src;
    in_source_ended_i    <= rec.ended;
    in_chromosome_code_i <= rec.chrom;
    in_interval_start_i  <= rec.begin_pos;
    in_interval_stop_i   <= rec.end_pos;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (merge_predict(rec, used, res)) pending_merges.push_back(res);
    if (used) taken_items++;
  endtask

  // Holds the input back until every expected result has left and the block has settled.
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_merges.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic apply_reset();
    shadow_active = fkm_pkg::ACTIVE_SOURCES_RST;
    shadow_target = fkm_pkg::TARGET_CHROMOSOME_RST;
    for (int i = 0; i < SOURCES; i++) begin
      shadow_begin[i]  = '0;
      shadow_end[i]    = '0;
      shadow_full[i]   = 1'b0;
      shadow_hungry[i] = 1'b1;
    end
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
  endtask

  // Filtering, ignored items, a start tie, both ends of the position range and a done result.
  task automatic test_filter_and_ties();
    cfg_write(fkm_pkg::CFG_ACTIVE_SOURCES, 5'd3);
    cfg_write(fkm_pkg::CFG_TARGET_CHROMOSOME, 5'd5);
    send_rec(4'd0, 1'b0, 5'd5, '1, '0);
    send_rec(4'd1, 1'b0, 5'd31, 32'h1234, 32'h5678);
    send_rec(4'd1, 1'b0, 5'd5, '0, '1);
    send_rec(4'd3, 1'b0, 5'd5, 32'd7, 32'd7);
    send_rec(4'd0, 1'b0, 5'd5, 32'd1, 32'd1);
    send_rec(4'd2, 1'b0, 5'd5, '0, 32'd7);
    send_rec(4'd1, 1'b1, '1, '1, '1);
    send_rec(4'd2, 1'b1, '0, '0, '0);
    send_rec(4'd0, 1'b1, '0, '0, '0);
    wait_idle();
  endtask

  // A zero count acts as one source and an oversize count as all sources.
  task automatic test_active_bounds();
    cfg_write(fkm_pkg::CFG_ACTIVE_SOURCES, 5'd0);
    cfg_write(fkm_pkg::CFG_TARGET_CHROMOSOME, 5'd31);
    send_rec(4'd1, 1'b0, 5'd31, 32'd9, 32'd9);
    send_rec(4'd0, 1'b0, 5'd31, 32'd5, 32'd6);
    send_rec(4'd0, 1'b1, '0, '0, '0);
    wait_idle();
    cfg_write(fkm_pkg::CFG_ACTIVE_SOURCES, 5'd31);
    cfg_write(fkm_pkg::CFG_TARGET_CHROMOSOME, 5'd22);
    send_rec(4'd15, 1'b0, 5'd22, '1, '0);
    for (int i = 0; i < SOURCES - 1; i++) send_rec(i[fkm_pkg::SRC_W-1:0], 1'b1, '1, '0, '1);
    send_rec(4'd15, 1'b1, '0, '0, '0);
    wait_idle();
  endtask

  // Shrinking the count so that no active source waits lets the next item emit.
  task automatic test_late_emission();
    cfg_write(fkm_pkg::CFG_ACTIVE_SOURCES, 5'd4);
    send_rec(4'd0, 1'b0, 5'd22, 32'd100, 32'd200);
    send_rec(4'd1, 1'b0, 5'd22, 32'd50, 32'd60);
    wait_idle();
    cfg_write(fkm_pkg::CFG_ACTIVE_SOURCES, 5'd2);
    send_rec(4'd3, 1'b0, 5'd22, 32'd1, 32'd2);
    send_rec(4'd1, 1'b1, '0, '0, '0);
    send_rec(4'd0, 1'b1, '0, '0, '0);
    wait_idle();
  endtask

  // Mostly well-formed passes with random content, plus noise, over several settings.
  task automatic test_random_merge();
    int                             goal;
    int                             candidates [$];
    int                             n;
    int                             pick;
    logic [31:0]                    draw;
    logic [fkm_pkg::SRC_W-1:0]      src;
    logic [fkm_pkg::CHROM_W-1:0]    chrom;
    logic [fkm_pkg::CFG_DATA_W-1:0] act;
    logic [fkm_pkg::CFG_DATA_W-1:0] tgt;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: act = 5'd16;
        1: act = 5'd1;
        2: act = 5'd2;
        3: act = 5'd17;
        4: act = 5'd0;
        5: act = 5'd31;
        6: act = 5'd5;
        default: begin
          draw = $urandom_range(2, 15);
          act  = draw[fkm_pkg::CFG_DATA_W-1:0];
        end
      endcase
      case (phase % 4)
        0: tgt = 5'd0;
        1: tgt = 5'd22;
        2: tgt = 5'd31;
        default: tgt = rand_chrom();
      endcase
      if ($urandom_range(0, 1)) begin
        cfg_write(fkm_pkg::CFG_ACTIVE_SOURCES, act);
        cfg_write(fkm_pkg::CFG_TARGET_CHROMOSOME, tgt);
      end else begin
        cfg_write(fkm_pkg::CFG_TARGET_CHROMOSOME, tgt);
        cfg_write(fkm_pkg::CFG_ACTIVE_SOURCES, act);
      end
      // Some phases run with one side never idling.
      src_idle  = (phase != 2);
      sink_idle = (phase != 3);
      goal = taken_items + 67;
      while (taken_items < goal) begin
        n = live_sources();
        candidates.delete();
        for (int i = 0; i < n; i++) if (shadow_hungry[i]) candidates.push_back(i);
        if (candidates.size() != 0 && $urandom_range(0, 99) < 85) begin
          pick = candidates[$urandom_range(0, candidates.size() - 1)];
          src  = pick[fkm_pkg::SRC_W-1:0];
          if ($urandom_range(0, 7) == 0) begin
            send_rec(src, 1'b1, rand_chrom(), $urandom, $urandom);
          end else begin
            chrom = ($urandom_range(0, 9) == 0) ? rand_chrom() : shadow_target;
            send_rec(src, 1'b0, chrom, rand_pos(), $urandom);
          end
        end else begin
          send_rec(rand_src(), rand_bit(), rand_chrom(), rand_pos(), $urandom);
        end
      end
      wait_idle();
    end
    src_idle  = 1'b1;
    sink_idle = 1'b1;
  endtask

  // Receiver stall: while the sink may idle, a random hold after each result transfer, sometimes also unprompted.
  always @(negedge clk_i) begin
    if (result_taken) begin
      result_taken = 1'b0;
      rx_hold = sink_idle ? $urandom_range(0, 3) : 0;
    end else if (rx_hold == 0 && sink_idle && $urandom_range(0, 15) == 0) begin
      rx_hold = $urandom_range(1, 3);
    end
    out_stall_i <= (rx_hold != 0);
    if (rx_hold != 0) rx_hold--;
  end

  // Compares each result transfer with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      result_taken = 1'b1;
      if (pending_merges.size() == 0) begin
        $error("unexpected result: start %h stop %h winner %0d done %0b", out_merged_start_o,
               out_merged_stop_o, out_winner_source_o, out_pass_done_o);
        errors++;
      end else begin
        next_merge = pending_merges.pop_front();
        if (out_merged_start_o !== next_merge.begin_pos) begin
          $error("merged_start: expected %h, got %h", next_merge.begin_pos, out_merged_start_o);
          errors++;
        end
        if (out_merged_stop_o !== next_merge.end_pos) begin
          $error("merged_stop: expected %h, got %h", next_merge.end_pos, out_merged_stop_o);
          errors++;
        end
        if (out_winner_source_o !== next_merge.winner) begin
          $error("winner_source: expected %0d, got %0d", next_merge.winner, out_winner_source_o);
          errors++;
        end
        if (out_pass_done_o !== next_merge.done) begin
          $error("pass_done: expected %0b, got %0b", next_merge.done, out_pass_done_o);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb: errors");
        $finish;
      end
    end
  end

  initial begin
    apply_reset();
    test_filter_and_ties();
    test_active_bounds();
    test_late_emission();
    test_random_merge();
    wait_idle();
    if (errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+sv
sv/fkm_pkg.sv
sv/fkm_ram.sv
sv/fkm_ctrl.sv
sv/fkm_dpath.sv
sv/filtered_k_way_merge.sv
test/tb.sv
